// ----- rtl/core/fmpd_pkg.sv -----
// Shared types, widths, codes and the arctangent table of the FM discriminator.
`timescale 1ns / 1ps
package fmpd_pkg;

    // Port field widths
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    // Datapath widths
    localparam int XY_W     = 52;   // vector components, headroom for CORDIC gain
    localparam int Z_W      = 34;   // angle accumulator, 2^31 = pi
    localparam int NORM_EXP = 46;   // normalize until larger magnitude >= 2^46
    localparam int TAB_LEN  = 24;
    localparam int STEP_W   = 5;

    // Multiply-accumulate operand selects
    localparam logic [1:0] MAC_II = 2'd0;   // re  = ci*li
    localparam logic [1:0] MAC_QQ = 2'd1;   // re += cq*lq
    localparam logic [1:0] MAC_QI = 2'd2;   // im  = cq*li
    localparam logic [1:0] MAC_IQ = 2'd3;   // im -= ci*lq

    // Vectoring unit commands
    localparam logic [2:0] VC_HOLD = 3'd0;
    localparam logic [2:0] VC_LOAD = 3'd1;
    localparam logic [2:0] VC_NORM = 3'd2;
    localparam logic [2:0] VC_FOLD = 3'd3;
    localparam logic [2:0] VC_ROT  = 3'd4;

    typedef struct packed {
        logic       issue;
        logic [1:0] sel;
    } t_mac_ctl;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [STEP_W-1:0] step;
    } t_vec_ctl;

    // atan(2^-k), 2^31 = pi
    function automatic logic [31:0] atan_val(input logic [STEP_W-1:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/fmpd_in_if.sv -----
// Input sample channel: valid/ready with I and Q.
`timescale 1ns / 1ps
interface fmpd_in_if;
    logic                       valid;
    logic                       ready;
    logic [fmpd_pkg::IN_W-1:0]  sample_i;
    logic [fmpd_pkg::IN_W-1:0]  sample_q;

    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

// ----- rtl/core/fmpd_out_if.sv -----
// Result channel: valid/ready with the phase step.
`timescale 1ns / 1ps
interface fmpd_out_if;
    logic                       valid;
    logic                       ready;
    logic [fmpd_pkg::OUT_W-1:0] phase_step;

    modport source (output valid, output phase_step, input ready);
    modport sink   (input valid, input phase_step, output ready);
endinterface

// ----- rtl/core/fmpd_mac.sv -----
// Single multiplier with accumulate: forms re/im of cur * conj(prev) from four products in turn.
`timescale 1ns / 1ps
module fmpd_mac #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  fmpd_pkg::t_mac_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]          i_cur_i,
    input  logic signed [SAMPLE_BITS-1:0]          i_cur_q,
    input  logic signed [SAMPLE_BITS-1:0]          i_prev_i,
    input  logic signed [SAMPLE_BITS-1:0]          i_prev_q,
    output logic signed [fmpd_pkg::XY_W-1:0]       o_re,
    output logic signed [fmpd_pkg::XY_W-1:0]       o_im
);
    localparam int PW = 2 * SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0]    w_a;
    logic signed [SAMPLE_BITS-1:0]    w_b;
    logic signed [PW-1:0]             r_prod;
    logic                             r_pv;
    logic [1:0]                       r_psel;
    logic signed [fmpd_pkg::XY_W-1:0] w_pext;
    logic signed [fmpd_pkg::XY_W-1:0] r_re;
    logic signed [fmpd_pkg::XY_W-1:0] r_im;

    always_comb begin
        case (i_ctl.sel)
            fmpd_pkg::MAC_II: begin w_a = i_cur_i; w_b = i_prev_i; end
            fmpd_pkg::MAC_QQ: begin w_a = i_cur_q; w_b = i_prev_q; end
            fmpd_pkg::MAC_QI: begin w_a = i_cur_q; w_b = i_prev_i; end
            fmpd_pkg::MAC_IQ: begin w_a = i_cur_i; w_b = i_prev_q; end
            default:          begin w_a = i_cur_i; w_b = i_prev_i; end
        endcase
    end

    assign w_pext = {{(fmpd_pkg::XY_W - PW){r_prod[PW-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        r_psel <= i_ctl.sel;
        if (r_pv) begin
            case (r_psel)
                fmpd_pkg::MAC_II: r_re <= w_pext;
                fmpd_pkg::MAC_QQ: r_re <= r_re + w_pext;
                fmpd_pkg::MAC_QI: r_im <= w_pext;
                fmpd_pkg::MAC_IQ: r_im <= r_im - w_pext;
                default:          r_re <= r_re;
            endcase
        end
    end

    assign o_re = r_re;
    assign o_im = r_im;
endmodule

// ----- rtl/core/fmpd_vec.sv -----
// CORDIC vectoring unit: normalize, quadrant fold, one rotation per cycle, rounding.
`timescale 1ns / 1ps
module fmpd_vec #(
    parameter int PHASE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fmpd_pkg::t_vec_ctl                 i_ctl,
    input  logic signed [fmpd_pkg::XY_W-1:0]   i_re,
    input  logic signed [fmpd_pkg::XY_W-1:0]   i_im,
    output logic [fmpd_pkg::OUT_W-1:0]         o_phase
);
    localparam int XW = fmpd_pkg::XY_W;
    localparam int ZW = fmpd_pkg::Z_W;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] RND     = ZW'(64'sd1 << (31 - PHASE_BITS));

    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_zero;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [ZW-1:0] w_atan;
    logic [5:0]           w_amt;
    logic [5:0]           w_exp;
    logic                 w_small;
    logic signed [ZW-1:0] w_rz;
    logic signed [ZW-1:0] w_sh;

    // |v| < 2^e
    function automatic logic fits(input logic signed [XW-1:0] v, input logic [5:0] e);
        logic signed [XW-1:0] lim;
        lim = (XW'(1) << e) - XW'(1);
        return (v <= lim) && (v >= -lim);
    endfunction

    // Greedy shift search 32,16,8,4,2,1 keeps the value below 2^46, then one final doubling.
    always_comb begin
        if (i_ctl.step < 5'd6) begin
            w_amt = 6'd32 >> i_ctl.step;
            w_exp = 6'(fmpd_pkg::NORM_EXP) - w_amt;
        end else begin
            w_amt = 6'd1;
            w_exp = 6'(fmpd_pkg::NORM_EXP);
        end
        w_small = fits(r_x, w_exp) && fits(r_y, w_exp);
    end

    assign w_xs   = r_x >>> i_ctl.step;
    assign w_ys   = r_y >>> i_ctl.step;
    assign w_atan = ZW'({2'b00, fmpd_pkg::atan_val(i_ctl.step)});

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        case (i_ctl.cmd)
            fmpd_pkg::VC_LOAD: begin
                n_x = i_re;
                n_y = i_im;
                n_z = '0;
            end
            fmpd_pkg::VC_NORM: begin
                if (w_small) begin
                    n_x = r_x <<< w_amt;
                    n_y = r_y <<< w_amt;
                end
            end
            fmpd_pkg::VC_FOLD: begin
                if (r_x < 0) begin
                    if (r_y >= 0) begin
                        n_x = r_y;
                        n_y = -r_x;
                        n_z = QUARTER;
                    end else begin
                        n_x = -r_y;
                        n_y = r_x;
                        n_z = -QUARTER;
                    end
                end
            end
            fmpd_pkg::VC_ROT: begin
                if (r_y >= 0) begin
                    n_x = r_x + w_ys;
                    n_y = r_y - w_xs;
                    n_z = r_z + w_atan;
                end else begin
                    n_x = r_x - w_ys;
                    n_y = r_y + w_xs;
                    n_z = r_z - w_atan;
                end
            end
            default: begin
                n_x = r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        if (i_ctl.cmd == fmpd_pkg::VC_LOAD) begin
            r_zero <= (i_re == '0) && (i_im == '0);
        end
    end

    assign w_rz = r_z + RND;
    assign w_sh = w_rz >>> (32 - PHASE_BITS);

    // Low PHASE_BITS bits, zero above; all zero for a zero product
    always_comb begin
        for (int b = 0; b < fmpd_pkg::OUT_W; b++) begin
            o_phase[b] = (b < PHASE_BITS) && !r_zero && w_sh[b];
        end
    end

    // i_rst_n is only used by assertions here
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zero |-> (o_phase == '0))
        else $error("zero product gave nonzero phase");
endmodule

// ----- rtl/core/fm_polar_discriminator_top.sv -----
// FM polar discriminator: angle of sample times conjugate of previous sample.
// Steps per result, in order: multiply-accumulate on one multiplier, load and normalize,
//   quadrant fold, min(ANGLE_STEPS, TAB_LEN) CORDIC rotations on one shared add/shift unit,
//   output load. A new sample is taken only in idle, not while the last is in work;
//   the first sample after reset gives no result. The output register frees the next accept.
// Reset (synchronous, active low) clears the sequencer, the held-sample flag and output valid.
`timescale 1ns / 1ps
module fm_polar_discriminator_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int PHASE_BITS  = 16,
    parameter int ANGLE_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fmpd_in_if.sink      i_in,
    fmpd_out_if.source   o_out
);
    localparam int ROT_STEPS = (ANGLE_STEPS < fmpd_pkg::TAB_LEN) ? ANGLE_STEPS
                                                                 : fmpd_pkg::TAB_LEN;
    localparam int XW = fmpd_pkg::XY_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_NORM = 3'd2;
    localparam logic [2:0] S_FOLD = 3'd3;
    localparam logic [2:0] S_ROT  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                        r_state;
    logic [2:0]                        n_state;
    logic [fmpd_pkg::STEP_W-1:0]       r_cnt;
    logic [fmpd_pkg::STEP_W-1:0]       n_cnt;
    logic                              r_have_last;
    logic signed [SAMPLE_BITS-1:0]     r_cur_i;
    logic signed [SAMPLE_BITS-1:0]     r_cur_q;
    logic signed [SAMPLE_BITS-1:0]     r_prev_i;
    logic signed [SAMPLE_BITS-1:0]     r_prev_q;
    logic signed [SAMPLE_BITS-1:0]     w_si;
    logic signed [SAMPLE_BITS-1:0]     w_sq;
    logic                              r_o_valid;
    logic [fmpd_pkg::OUT_W-1:0]        r_o_phase;
    logic                              w_acc;
    logic                              w_load_out;
    fmpd_pkg::t_mac_ctl                w_mac_ctl;
    fmpd_pkg::t_vec_ctl                w_vec_ctl;
    logic signed [XW-1:0]              w_re;
    logic signed [XW-1:0]              w_im;
    logic [fmpd_pkg::OUT_W-1:0]        w_phase;

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_load_out  = (r_state == S_DONE) && (!r_o_valid || o_out.ready);

    // Low SAMPLE_BITS of each field, zero beyond the port width
    always_comb begin
        for (int b = 0; b < SAMPLE_BITS; b++) begin
            w_si[b] = (b < fmpd_pkg::IN_W) && i_in.sample_i[b];
            w_sq[b] = (b < fmpd_pkg::IN_W) && i_in.sample_q[b];
        end
    end

    always_comb begin
        n_state             = r_state;
        n_cnt               = r_cnt;
        w_mac_ctl.issue     = 1'b0;
        w_mac_ctl.sel       = r_cnt[1:0];
        w_vec_ctl.cmd       = fmpd_pkg::VC_HOLD;
        w_vec_ctl.step      = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_acc && r_have_last) begin
                    n_state = S_MAC;
                    n_cnt   = '0;
                end
            end
            S_MAC: begin
                w_mac_ctl.issue = (r_cnt < 5'd4);
                if (r_cnt == 5'd4) begin
                    n_state = S_NORM;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_NORM: begin
                if (r_cnt == 5'd0) begin
                    w_vec_ctl.cmd = fmpd_pkg::VC_LOAD;
                end else begin
                    w_vec_ctl.cmd  = fmpd_pkg::VC_NORM;
                    w_vec_ctl.step = r_cnt - 5'd1;
                end
                if (r_cnt == 5'd7) begin
                    n_state = S_FOLD;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_FOLD: begin
                w_vec_ctl.cmd = fmpd_pkg::VC_FOLD;
                n_state       = S_ROT;
                n_cnt         = '0;
            end
            S_ROT: begin
                w_vec_ctl.cmd = fmpd_pkg::VC_ROT;
                if (r_cnt == 5'(ROT_STEPS - 1)) begin
                    n_state = S_DONE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_have_last <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_acc) begin
                r_have_last <= 1'b1;
            end
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cur_i  <= w_si;
            r_cur_q  <= w_sq;
            r_prev_i <= r_cur_i;
            r_prev_q <= r_cur_q;
        end
        if (w_load_out) begin
            r_o_phase <= w_phase;
        end
    end

    fmpd_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_cur_i  (r_cur_i),
        .i_cur_q  (r_cur_q),
        .i_prev_i (r_prev_i),
        .i_prev_q (r_prev_q),
        .o_re     (w_re),
        .o_im     (w_im)
    );

    fmpd_vec #(
        .PHASE_BITS (PHASE_BITS)
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_vec_ctl),
        .i_re    (w_re),
        .i_im    (w_im),
        .o_phase (w_phase)
    );

    assign o_out.valid      = r_o_valid;
    assign o_out.phase_step = r_o_phase;

    a_first_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !r_have_last) |=> (r_state == S_IDLE))
        else $error("first item started a computation");

    a_start_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_have_last) |=> (r_state == S_MAC) && (r_cnt == '0))
        else $error("item with held sample did not start the multiply");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without finishing the rotations");

    a_rot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (r_cnt < 5'(ROT_STEPS)))
        else $error("rotation counter past last step");
endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the FM polar discriminator: random FM phasors, noise and extremes.
`timescale 1ns / 1ps
module tb;

    localparam int SAMPLE_BITS = 16;
    localparam int PHASE_BITS  = 16;
    localparam int ANGLE_STEPS = 16;
    localparam int LUT_LEN     = 24;
    localparam int RANDOM_ITEMS = 1950;
    localparam int DRAIN_CYCLES = 2 * (ANGLE_STEPS + 16);

    typedef struct {
        logic [fmpd_pkg::IN_W-1:0] i;
        logic [fmpd_pkg::IN_W-1:0] q;
        int                        gap;   // idle cycles before this item is offered
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fmpd_in_if  in_ch();
    fmpd_out_if out_ch();

    fm_polar_discriminator_top #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .PHASE_BITS (PHASE_BITS),
        .ANGLE_STEPS(ANGLE_STEPS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    // atan(2^-k), 2^31 = pi
    longint atan_lut [0:LUT_LEN-1] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    t_sample                    pending[$];
    logic [fmpd_pkg::OUT_W-1:0] exp_phase_q[$];
    longint          prev_i = 0;
    longint          prev_q = 0;
    bit              have_prev = 1'b0;
    int              n_errors = 0;
    int              n_accepted = 0;
    int              n_stim = 0;
    logic            hold_off = 1'b0;

    function automatic longint mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // CORDIC vectoring angle of (x, y); 2^(PHASE_BITS-1) = pi
    function automatic logic [fmpd_pkg::OUT_W-1:0] phase_of(longint re, longint im);
        longint x, y, z, t, xs, ys, r;
        longint norm_lim;
        logic [63:0] rb;
        norm_lim = longint'(1) << 46;
        x = re;
        y = im;
        z = 0;
        if (x == 0 && y == 0)
            return '0;
        while (mag64(x) < norm_lim && mag64(y) < norm_lim) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = atan_lut[0] * 2;
            end else begin
                x = -y;
                y = t;
                z = -atan_lut[0] * 2;
            end
        end
        for (int k = 0; k < ANGLE_STEPS && k < LUT_LEN; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_lut[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_lut[k];
            end
        end
        r = (z + (longint'(1) << (31 - PHASE_BITS))) >>> (32 - PHASE_BITS);
        rb = r;
        return rb[fmpd_pkg::OUT_W-1:0];
    endfunction

    function automatic void predict_sample(logic [fmpd_pkg::IN_W-1:0] si,
                                           logic [fmpd_pkg::IN_W-1:0] sq);
        longint ci, cq, re, im;
        ci = longint'($signed(si[SAMPLE_BITS-1:0]));
        cq = longint'($signed(sq[SAMPLE_BITS-1:0]));
        re = ci * prev_i + cq * prev_q;
        im = cq * prev_i - ci * prev_q;
        if (have_prev)
            exp_phase_q.insert(exp_phase_q.size(), phase_of(re, im));
        prev_i = ci;
        prev_q = cq;
        have_prev = 1'b1;
    endfunction

    function automatic int pick_idle(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic void push_sample(int si, int sq, bit quiet);
        t_sample s;
        logic [31:0] vi, vq;
        vi = si;
        vq = sq;
        s.i = vi[fmpd_pkg::IN_W-1:0];
        s.q = vq[fmpd_pkg::IN_W-1:0];
        s.gap = pick_idle(quiet);
        pending.insert(pending.size(), s);
        n_stim++;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 6))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            default: return 32767;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [fmpd_pkg::OUT_W-1:0] got,
                                   logic [fmpd_pkg::OUT_W-1:0] want);
        n_errors++;
        $display("tb: mismatch %s: got %0d expected %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
    endtask

    // driver: offers pending items, predicts each accepted one
    always @(posedge i_clk) begin
        t_sample nxt;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_sample(in_ch.sample_i, in_ch.sample_q);
                n_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (pending[0].gap > 0) begin
                    pending[0].gap = pending[0].gap - 1;
                    in_ch.valid <= 1'b0;
                end else begin
                    nxt = pending.pop_front();
                    in_ch.sample_i <= nxt.i;
                    in_ch.sample_q <= nxt.q;
                    in_ch.valid <= 1'b1;
                end
            end
        end
    end

    // monitor: random backpressure, compares each result with the oldest prediction
    int stall_left = 0;
    int mon_cycle = 0;
    always @(posedge i_clk) begin
        logic [fmpd_pkg::OUT_W-1:0] want;
        bit quiet;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            mon_cycle++;
            quiet = ((mon_cycle / 3000) % 4) == 0;
            if (out_ch.valid && out_ch.ready) begin
                if (exp_phase_q.size() == 0) begin
                    report_mismatch("unexpected result", out_ch.phase_step, '0);
                end else begin
                    want = exp_phase_q.pop_front();
                    if (out_ch.phase_step !== want)
                        report_mismatch("phase_step", out_ch.phase_step, want);
                end
            end
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    stall_left = 1 + pick_idle(1'b0);
            end
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin
        while (n_accepted < 300)
            @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int kind, len, amp, vi, vq, target;
        bit quiet;
        real ph, dph;

        i_rst_n = 1'b0;

        // directed: first sample loads only, quarter turns, pi wrap, zeros, extremes
        push_sample(1000, 0, 1'b0);
        push_sample(1000, 0, 1'b0);
        push_sample(0, 1000, 1'b0);
        push_sample(-1000, 0, 1'b0);
        push_sample(1000, 0, 1'b0);
        push_sample(0, 0, 1'b0);
        push_sample(0, 0, 1'b0);
        push_sample(32767, 32767, 1'b0);
        push_sample(-32768, -32768, 1'b0);
        push_sample(-32768, -32768, 1'b0);
        push_sample(-32768, 32767, 1'b0);
        push_sample(32767, -32768, 1'b0);
        push_sample(1, 0, 1'b0);
        push_sample(-100, -1, 1'b0);
        push_sample(-100, 1, 1'b0);
        push_sample(1, -1, 1'b0);
        push_sample(-32768, 0, 1'b0);
        push_sample(0, -32768, 1'b0);
        push_sample(32767, 0, 1'b0);
        push_sample(0, 32767, 1'b0);
        push_sample(-1, -1, 1'b0);
        push_sample(1, 1, 1'b0);

        target = n_stim + RANDOM_ITEMS;
        while (n_stim < target) begin
            kind = $urandom_range(0, 9);
            len = $urandom_range(20, 90);
            quiet = ($urandom_range(0, 4) == 0);
            // FM-like phasor bursts make up most of the traffic
            amp = $urandom_range(0, 1) ? $urandom_range(16000, 32767) : $urandom_range(1, 300);
            ph = $urandom_range(0, 6283) / 1000.0;
            dph = ($urandom_range(0, 2000) - 1000.0) / 1000.0 * 3.14159;
            if ($urandom_range(0, 1))
                dph = dph / 16.0;
            for (int n = 0; n < len; n++) begin
                case (kind)
                    6: begin
                        vi = $urandom_range(0, 65535) - 32768;
                        vq = $urandom_range(0, 65535) - 32768;
                    end
                    7: begin
                        vi = $urandom_range(0, 8) - 4;
                        vq = $urandom_range(0, 8) - 4;
                    end
                    8: begin
                        vi = pick_extreme();
                        vq = pick_extreme();
                    end
                    9: begin
                        vi = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 65535) - 32768;
                        vq = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 65535) - 32768;
                    end
                    default: begin
                        vi = $rtoi(amp * $cos(ph));
                        vq = $rtoi(amp * $sin(ph));
                        ph = ph + dph;
                        if ($urandom_range(0, 15) == 0)
                            dph = ($urandom_range(0, 2000) - 1000.0) / 1000.0 * 3.14159;
                    end
                endcase
                push_sample(vi, vq, quiet);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        while (exp_phase_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && exp_phase_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
